// ----- hdl/tdps_pkg.sv -----
// Package for the three-drone proximity supervisor.
// Shared types, codes and case tables; no dependencies.
`default_nettype none
package tdps_pkg;

    localparam int STATUS_BITS = 4;
    localparam int HOV_BITS    = 2;
    localparam int KIND_BITS   = 3;

    localparam logic [KIND_BITS-1:0] KIND_TICK    = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_LEADER  = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_FIRST   = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_SECOND  = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_TGT_ONE = 3'd4;
    localparam logic [KIND_BITS-1:0] KIND_TGT_TWO = 3'd5;

    localparam logic CFG_CRASH = 1'b0;
    localparam logic CFG_AVOID = 1'b1;

    localparam logic [HOV_BITS-1:0] HOV_NONE    = 2'd0;
    localparam logic [HOV_BITS-1:0] HOV_RELEASE = 2'd1;
    localparam logic [HOV_BITS-1:0] HOV_HOLD    = 2'd2;

    localparam logic [1:0] MODE_UNSET  = 2'd0;
    localparam logic [1:0] MODE_STOP   = 2'd1;
    localparam logic [1:0] MODE_TRYING = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_CLEAR      = 4'd0;
    localparam logic [STATUS_BITS-1:0] ST_WARN_LF    = 4'd1;
    localparam logic [STATUS_BITS-1:0] ST_MULTI_WARN = 4'd4;
    localparam logic [STATUS_BITS-1:0] ST_CRASH_LF   = 4'd5;
    localparam logic [STATUS_BITS-1:0] ST_CRASH_LS   = 4'd6;
    localparam logic [STATUS_BITS-1:0] ST_CRASH_FS   = 4'd7;
    localparam logic [STATUS_BITS-1:0] ST_MULTI_CRSH = 4'd8;

    // Per avoidance case: held drones, tried follower, reference drones, closing pairs.
    localparam logic [2:0] CASE_HOLD [4] = '{3'd3, 3'd5, 3'd6, 3'd7};
    localparam logic [1:0] CASE_FOLL [4] = '{2'd1, 2'd2, 2'd1, 2'd2};
    localparam logic [2:0] CASE_REFS [4] = '{3'd1, 3'd1, 3'd4, 3'd3};
    localparam logic [2:0] CASE_CLOS [4] = '{3'd1, 3'd2, 3'd4, 3'd6};

    // Sequencer states of the back end.
    typedef enum logic [3:0] {
        S_IDLE,
        S_PAIR_SUB,
        S_PAIR_SQ,
        S_PAIR_ACC,
        S_STATUS,
        S_REJ_SCAN,
        S_REF_SUB,
        S_REF_SQ,
        S_REF_ACC,
        S_DECIDE,
        S_EMIT
    } seq_state_t;

endpackage
`default_nettype wire

// ----- hdl/tdps_ram.sv -----
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
`default_nettype none
module tdps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- hdl/tdps_front.sv -----
// Front end: accepts words, drops unknown kinds, and queues them for the back end.
// Uses tdps_pkg.
`default_nettype none
module tdps_front #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    output logic                          full,
    input  wire logic [2:0]               kind,
    input  wire logic [COORD_BITS-1:0]    coord_x,
    input  wire logic [COORD_BITS-1:0]    coord_y,
    input  wire logic [COORD_BITS-1:0]    coord_z,
    output logic                          q_valid,
    input  wire logic                     q_take,
    output logic [2:0]                    q_kind,
    output logic [3*COORD_BITS-1:0]       q_coord
);
    localparam int W = 3 + 3 * COORD_BITS;

    logic [W-1:0] slot_reg [2];
    logic [1:0]   cnt_reg, cnt_next;
    logic         wr_reg, wr_next, rd_reg, rd_next;
    logic         known, wr_en, rd_en;

    assign known = (kind <= tdps_pkg::KIND_TGT_TWO);
    assign full  = (cnt_reg == 2'd2);
    assign wr_en = push && !full && known;
    assign rd_en = q_take && (cnt_reg != 2'd0);

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        wr_next  = wr_reg ^ wr_en;
        rd_next  = rd_reg ^ rd_en;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_reg] <= {kind, coord_x, coord_y, coord_z};
        end
    end

    assign q_valid = (cnt_reg != 2'd0);
    assign q_kind  = slot_reg[rd_reg][W-1 -: 3];
    assign q_coord = slot_reg[rd_reg][3*COORD_BITS-1:0];
endmodule
`default_nettype wire

// ----- hdl/tdps_back.sv -----
// Back end: stores positions and targets, runs distance checks and the
// per-case mode sequencer, and holds one finished result. Uses tdps_pkg, tdps_ram.
`default_nettype none
module tdps_back #(
    parameter int COORD_BITS   = 16,
    parameter int REJECT_DEPTH = 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic                   cfg_index,
    input  wire logic [15:0]            cfg_data,
    input  wire logic                   q_valid,
    output logic                        q_take,
    input  wire logic [2:0]             q_kind,
    input  wire logic [3*COORD_BITS-1:0] q_coord,
    output logic                        empty,
    input  wire logic                   pop,
    output logic [3:0]                  status,
    output logic [1:0]                  hover_leader,
    output logic [1:0]                  hover_first,
    output logic [1:0]                  hover_second,
    output logic                        reset_first,
    output logic                        reset_second
);
    localparam int CB   = COORD_BITS;
    localparam int DB   = CB + 1;          // difference width
    localparam int SQB  = 2 * DB;          // square width
    localparam int SUMB = SQB + 2;         // sum of three squares
    localparam int RIB  = (REJECT_DEPTH > 1) ? $clog2(REJECT_DEPTH) : 1;
    localparam int CNTB = $clog2(REJECT_DEPTH + 1);
    localparam int RAB  = 2 + RIB;
    localparam int RDEP = 4 << RIB;
    localparam int PW   = 3 * CB;

    logic [15:0] crash_reg, avoid_reg;
    logic [31:0] rz2_reg, ra2_reg;

    logic [PW-1:0] pos_reg [3];
    logic [PW-1:0] tgt_reg [2];
    logic [PW-1:0] tried_reg [4];
    logic [SUMB-1:0] prev_reg [3];
    logic [2:0]      clos_reg;
    logic [1:0]      mode_reg [4];
    logic [CNTB-1:0] rcnt_reg [4];

    tdps_pkg::seq_state_t st_reg, st_next;
    logic [1:0]      pair_reg, axis_reg;      // pair or reference index, axis
    logic [DB-1:0]   diff_reg;
    logic [SQB-1:0]  sq_reg;
    logic [SUMB-1:0] acc_reg;
    logic [1:0]      band_reg [3];
    logic [1:0]      case_reg;
    logic [3:0]      st_code_reg;
    logic            bad_reg, near_reg;
    logic [RIB-1:0]  scan_reg;
    logic            scan_live_reg;

    logic            out_full_reg;
    logic [3:0]      o_status_reg;
    logic [1:0]      o_hov_reg [3];
    logic            o_r1_reg, o_r2_reg;

    // Rejected-target store.
    logic            ram_we;
    logic [RAB-1:0]  ram_waddr, ram_raddr;
    logic [PW-1:0]   ram_rdata;

    tdps_ram #(.WIDTH(PW), .DEPTH(RDEP)) u_rej (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(tried_reg[case_reg]),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );
    // While scanning, the address runs one entry ahead of the compared entry.
    assign ram_raddr = {case_reg, scan_live_reg ? scan_reg + RIB'(1) : scan_reg};

    // Operand selection for the shared subtract / square unit.
    logic [PW-1:0] opa, opb;
    logic [CB-1:0] ca, cb;
    logic [1:0]    pa, pb;
    logic [1:0]    foll;
    always_comb
    begin
        foll = tdps_pkg::CASE_FOLL[case_reg];
        pa = (pair_reg == 2'd2) ? 2'd1 : 2'd0;
        pb = (pair_reg == 2'd0) ? 2'd1 : 2'd2;
        if (st_reg == tdps_pkg::S_PAIR_SUB)
        begin
            opa = pos_reg[pa];
            opb = pos_reg[pb];
        end
        else
        begin
            opa = tgt_reg[foll[1]];
            opb = pos_reg[pair_reg];
        end
        case (axis_reg)
            2'd0:    begin ca = opa[PW-1 -: CB];   cb = opb[PW-1 -: CB];   end
            2'd1:    begin ca = opa[2*CB-1 -: CB]; cb = opb[2*CB-1 -: CB]; end
            default: begin ca = opa[CB-1:0];       cb = opb[CB-1:0];       end
        endcase
    end

    logic signed [DB-1:0] dsum;
    logic [DB-1:0]        dabs;
    logic [SUMB-1:0]      acc_sum;
    assign dsum    = $signed({ca[CB-1], ca}) - $signed({cb[CB-1], cb});
    assign dabs    = dsum[DB-1] ? DB'(-dsum) : DB'(dsum);
    assign acc_sum = acc_reg + SUMB'(sq_reg);

    // Status from the three bands.
    logic [3:0] code;
    logic [1:0] nband;
    logic       any_crash;
    always_comb
    begin
        code = tdps_pkg::ST_CLEAR;
        nband = '0;
        any_crash = 1'b0;
        for (int p = 0; p < 3; p++)
        begin
            if (band_reg[p] != 2'd0)
            begin
                nband = nband + 2'd1;
                code = (band_reg[p] == 2'd2) ? tdps_pkg::ST_CRASH_LF + 4'(p)
                                             : tdps_pkg::ST_WARN_LF + 4'(p);
            end
            if (band_reg[p] == 2'd2)
            begin
                any_crash = 1'b1;
            end
        end
        if (nband >= 2'd2)
        begin
            code = any_crash ? tdps_pkg::ST_MULTI_CRSH : tdps_pkg::ST_MULTI_WARN;
        end
    end

    logic last_axis, scan_end, closing, rej_hit;
    logic [CNTB-1:0] cur_cnt;
    assign last_axis = (axis_reg == 2'd2);
    assign cur_cnt   = rcnt_reg[case_reg];
    assign scan_end  = (CNTB'(scan_reg) + CNTB'(1) >= cur_cnt) ||
                       (CNTB'(scan_reg) == CNTB'(REJECT_DEPTH - 1));
    assign closing   = |(tdps_pkg::CASE_CLOS[case_reg] & clos_reg);
    assign rej_hit   = scan_live_reg && (ram_rdata == tgt_reg[foll[1]]);

    // Next state.
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            tdps_pkg::S_IDLE:
                if (q_valid && !out_full_reg && q_kind == tdps_pkg::KIND_TICK)
                    st_next = tdps_pkg::S_PAIR_SUB;
            tdps_pkg::S_PAIR_SUB: st_next = tdps_pkg::S_PAIR_SQ;
            tdps_pkg::S_PAIR_SQ:  st_next = tdps_pkg::S_PAIR_ACC;
            tdps_pkg::S_PAIR_ACC:
                if (last_axis && pair_reg == 2'd2) st_next = tdps_pkg::S_STATUS;
                else                               st_next = tdps_pkg::S_PAIR_SUB;
            tdps_pkg::S_STATUS:
                if (code >= tdps_pkg::ST_WARN_LF && code <= tdps_pkg::ST_MULTI_WARN
                    && mode_reg[code[1:0] - 2'd1] == tdps_pkg::MODE_STOP)
                    st_next = (rcnt_reg[code[1:0] - 2'd1] != '0)
                              ? tdps_pkg::S_REJ_SCAN : tdps_pkg::S_REF_SUB;
                else
                    st_next = tdps_pkg::S_DECIDE;
            tdps_pkg::S_REJ_SCAN:
                if (scan_end && !scan_live_reg) st_next = tdps_pkg::S_REJ_SCAN;
                else if (!scan_live_reg)        st_next = tdps_pkg::S_REJ_SCAN;
                else if (rej_hit || bad_reg)    st_next = tdps_pkg::S_DECIDE;
                else if (scan_end)              st_next = tdps_pkg::S_REF_SUB;
            tdps_pkg::S_REF_SUB:  st_next = tdps_pkg::S_REF_SQ;
            tdps_pkg::S_REF_SQ:   st_next = tdps_pkg::S_REF_ACC;
            tdps_pkg::S_REF_ACC:
                if (last_axis && pair_reg == 2'd2) st_next = tdps_pkg::S_DECIDE;
                else                               st_next = tdps_pkg::S_REF_SUB;
            tdps_pkg::S_DECIDE:   st_next = tdps_pkg::S_EMIT;
            tdps_pkg::S_EMIT:     st_next = tdps_pkg::S_IDLE;
            default:              st_next = tdps_pkg::S_IDLE;
        endcase
    end

    // Queue take and RAM write strobes.
    always_comb
    begin
        q_take    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = {case_reg, cur_cnt[RIB-1:0]};
        case (st_reg)
            tdps_pkg::S_IDLE:
                q_take = q_valid && !out_full_reg && q_kind != tdps_pkg::KIND_TICK;
            tdps_pkg::S_EMIT:
                q_take = 1'b1;
            tdps_pkg::S_DECIDE:
                ram_we = (st_code_reg >= tdps_pkg::ST_WARN_LF)
                         && (st_code_reg <= tdps_pkg::ST_MULTI_WARN)
                         && mode_reg[case_reg] == tdps_pkg::MODE_TRYING && closing
                         && cur_cnt < CNTB'(REJECT_DEPTH);
            default: ;
        endcase
    end

    logic [SUMB-1:0] ra2w, rz2w;
    assign ra2w = SUMB'(ra2_reg);
    assign rz2w = SUMB'(rz2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= tdps_pkg::S_IDLE;
            crash_reg    <= 16'd179;
            avoid_reg    <= 16'd256;
            rz2_reg      <= 32'd179 * 32'd179;
            ra2_reg      <= 32'd256 * 32'd256;
            clos_reg     <= '0;
            out_full_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i]  <= '0;
                prev_reg[i] <= '0;
            end
            for (int i = 0; i < 2; i++)
                tgt_reg[i] <= '0;
            for (int i = 0; i < 4; i++)
            begin
                mode_reg[i] <= tdps_pkg::MODE_UNSET;
                rcnt_reg[i] <= '0;
            end
        end
        else
        begin
            st_reg  <= st_next;
            rz2_reg <= crash_reg * crash_reg;
            ra2_reg <= avoid_reg * avoid_reg;
            if (cfg_we)
            begin
                if (cfg_index == tdps_pkg::CFG_CRASH) crash_reg <= cfg_data;
                else                                  avoid_reg <= cfg_data;
            end
            if (pop && out_full_reg)
                out_full_reg <= 1'b0;
            if (st_reg == tdps_pkg::S_IDLE && q_take)
            begin
                case (q_kind)
                    tdps_pkg::KIND_LEADER:  pos_reg[0] <= q_coord;
                    tdps_pkg::KIND_FIRST:   pos_reg[1] <= q_coord;
                    tdps_pkg::KIND_SECOND:  pos_reg[2] <= q_coord;
                    tdps_pkg::KIND_TGT_ONE: tgt_reg[0] <= q_coord;
                    tdps_pkg::KIND_TGT_TWO: tgt_reg[1] <= q_coord;
                    default: ;
                endcase
            end
            if (st_reg == tdps_pkg::S_PAIR_ACC && last_axis)
            begin
                prev_reg[pair_reg] <= acc_sum;
                if (acc_sum > rz2w && acc_sum <= ra2w)
                    clos_reg[pair_reg] <= acc_sum < prev_reg[pair_reg];
            end
            if (st_reg == tdps_pkg::S_STATUS && code >= tdps_pkg::ST_WARN_LF
                && code <= tdps_pkg::ST_MULTI_WARN)
            begin
                for (int i = 0; i < 4; i++)
                    if (i != int'(code) - 1) mode_reg[i] <= tdps_pkg::MODE_STOP;
            end
            if (st_reg == tdps_pkg::S_STATUS && code == tdps_pkg::ST_CLEAR)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mode_reg[i] <= tdps_pkg::MODE_STOP;
                    rcnt_reg[i] <= '0;
                end
            end
            if (st_reg == tdps_pkg::S_DECIDE && st_code_reg >= tdps_pkg::ST_WARN_LF
                && st_code_reg <= tdps_pkg::ST_MULTI_WARN)
            begin
                if (mode_reg[case_reg] == tdps_pkg::MODE_STOP && !bad_reg && !near_reg)
                begin
                    mode_reg[case_reg]  <= tdps_pkg::MODE_TRYING;
                end
                else if (mode_reg[case_reg] == tdps_pkg::MODE_TRYING && closing)
                begin
                    mode_reg[case_reg] <= tdps_pkg::MODE_STOP;
                    if (ram_we) rcnt_reg[case_reg] <= cur_cnt + CNTB'(1);
                end
            end
            if (st_reg == tdps_pkg::S_EMIT)
                out_full_reg <= 1'b1;
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge clk)
    begin
        case (st_reg)
            tdps_pkg::S_IDLE:
            begin
                pair_reg <= 2'd0;
                axis_reg <= 2'd0;
                acc_reg  <= '0;
            end
            tdps_pkg::S_PAIR_SUB, tdps_pkg::S_REF_SUB:
                diff_reg <= dabs;
            tdps_pkg::S_PAIR_SQ, tdps_pkg::S_REF_SQ:
                sq_reg <= diff_reg * diff_reg;
            tdps_pkg::S_PAIR_ACC:
            begin
                if (last_axis)
                begin
                    band_reg[pair_reg] <= (acc_sum <= rz2w) ? 2'd2 :
                                          (acc_sum <= ra2w) ? 2'd1 : 2'd0;
                    acc_reg  <= '0;
                    axis_reg <= 2'd0;
                    pair_reg <= pair_reg + 2'd1;
                end
                else
                begin
                    acc_reg  <= acc_sum;
                    axis_reg <= axis_reg + 2'd1;
                end
            end
            tdps_pkg::S_STATUS:
            begin
                st_code_reg   <= code;
                case_reg      <= code[1:0] - 2'd1;
                bad_reg       <= 1'b0;
                near_reg      <= 1'b0;
                scan_reg      <= '0;
                scan_live_reg <= 1'b0;
                pair_reg      <= 2'd0;
                axis_reg      <= 2'd0;
                acc_reg       <= '0;
            end
            tdps_pkg::S_REJ_SCAN:
            begin
                // Read data is registered and appears in the cycle after its address.
                if (!scan_live_reg)
                    scan_live_reg <= 1'b1;
                else
                begin
                    if (rej_hit) bad_reg <= 1'b1;
                    if (!scan_end) scan_reg <= scan_reg + RIB'(1);
                    else scan_live_reg <= 1'b0;
                end
            end
            tdps_pkg::S_REF_ACC:
            begin
                if (last_axis)
                begin
                    if (tdps_pkg::CASE_REFS[case_reg][pair_reg] && acc_sum <= ra2w)
                        near_reg <= 1'b1;
                    acc_reg  <= '0;
                    axis_reg <= 2'd0;
                    pair_reg <= pair_reg + 2'd1;
                end
                else
                begin
                    acc_reg  <= acc_sum;
                    axis_reg <= axis_reg + 2'd1;
                end
            end
            tdps_pkg::S_DECIDE:
            begin
                o_status_reg <= st_code_reg;
                o_r1_reg <= (st_code_reg == tdps_pkg::ST_CRASH_LF)
                         || (st_code_reg == tdps_pkg::ST_MULTI_CRSH);
                o_r2_reg <= (st_code_reg == tdps_pkg::ST_CRASH_LS)
                         || (st_code_reg == tdps_pkg::ST_CRASH_FS)
                         || (st_code_reg == tdps_pkg::ST_MULTI_CRSH);
                for (int i = 0; i < 3; i++)
                    o_hov_reg[i] <= tdps_pkg::HOV_NONE;
                if (st_code_reg == tdps_pkg::ST_CLEAR)
                begin
                    for (int i = 0; i < 3; i++)
                        o_hov_reg[i] <= tdps_pkg::HOV_RELEASE;
                end
                else if (st_code_reg <= tdps_pkg::ST_MULTI_WARN
                         && mode_reg[case_reg] == tdps_pkg::MODE_STOP)
                begin
                    for (int i = 0; i < 3; i++)
                        if (tdps_pkg::CASE_HOLD[case_reg][i])
                            o_hov_reg[i] <= tdps_pkg::HOV_HOLD;
                    if (!bad_reg && !near_reg)
                    begin
                        o_hov_reg[foll] <= tdps_pkg::HOV_RELEASE;
                        tried_reg[case_reg] <= tgt_reg[foll[1]];
                    end
                end
            end
            default: ;
        endcase
    end

    assign empty        = !out_full_reg;
    assign status       = o_status_reg;
    assign hover_leader = o_hov_reg[0];
    assign hover_first  = o_hov_reg[1];
    assign hover_second = o_hov_reg[2];
    assign reset_first  = o_r1_reg;
    assign reset_second = o_r2_reg;
endmodule
`default_nettype wire

// ----- hdl/three_drone_proximity_supervisor.sv -----
// Top level of the three-drone proximity supervisor.
// Uses tdps_pkg, tdps_front, tdps_back.
//
// Words enter through push/full: kind selects a position update (leader,
// first, second follower), a follower target update, or a tick. Kinds 6 and 7
// are dropped. Updates give no result; the back end absorbs them while idle.
// A tick gives one result word on empty/pop: a status code, the hover command
// per drone and crash reset flags.
// A tick runs three pairwise squared distances through one shared
// subtract/square/accumulate unit, then, in an avoidance case, scans the
// case's rejected-target list in a RAM (one entry per cycle) and checks the
// target against up to two drones.
// A two-word queue separates the front end from the back end. The result
// register holds one word; while it is not popped, the back end waits and
// the front queue fills, then full rises.
// Reset restores the default radii (0.7 m crash, 1.0 m avoid), clears all
// positions, targets, modes and list counts. The user must write the
// cfg_we/cfg_index/cfg_data configuration only while idle (not enforced).
`default_nettype none
module three_drone_proximity_supervisor #(
    parameter int COORD_BITS   = 16,
    parameter int REJECT_DEPTH = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [15:0]           cfg_data,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [2:0]            kind,
    input  wire logic [COORD_BITS-1:0] coord_x,
    input  wire logic [COORD_BITS-1:0] coord_y,
    input  wire logic [COORD_BITS-1:0] coord_z,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [3:0]                 status,
    output logic [1:0]                 hover_leader,
    output logic [1:0]                 hover_first,
    output logic [1:0]                 hover_second,
    output logic                       reset_first,
    output logic                       reset_second
);
    logic                      q_valid, q_take;
    logic [2:0]                q_kind;
    logic [3*COORD_BITS-1:0]   q_coord;

    tdps_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .kind(kind),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .q_valid(q_valid), .q_take(q_take), .q_kind(q_kind), .q_coord(q_coord)
    );

    tdps_back #(.COORD_BITS(COORD_BITS), .REJECT_DEPTH(REJECT_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .q_valid(q_valid), .q_take(q_take),
        .q_kind(q_kind), .q_coord(q_coord), .empty(empty), .pop(pop),
        .status(status), .hover_leader(hover_leader), .hover_first(hover_first),
        .hover_second(hover_second), .reset_first(reset_first),
        .reset_second(reset_second)
    );
endmodule
`default_nettype wire
